// ===== hdl/fbfl_pkg.sv =====
`timescale 1ns / 1ps

package fbfl_pkg;

    // Defaults for the top-level parameters.
    localparam int unsigned NUM_BLOCKS_DEF  = 256;
    localparam int unsigned COUNT_WIDTH_DEF = 32;

    // Fixed field widths of the two channels and the register.
    localparam int unsigned IDX_W     = 8;
    localparam int unsigned BC_W      = 9;
    localparam int unsigned OUT_CNT_W = 32;

    // Reset value of the block count register, before limiting to the pool size.
    localparam logic [BC_W-1:0] BC_RESET = 9'd256;

    // Depth of the queue between the front and the back.
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

    // Operation codes of the input item.
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    // Classified command as it travels from the front to the back.
    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_REJECT  = 2'd2
    } t_cmd;

    typedef struct packed {
        logic             operation;
        logic [IDX_W-1:0] release_index;
    } t_request;

    typedef struct packed {
        t_status              status;
        logic [IDX_W-1:0]     granted_index;
        logic [BC_W-1:0]      free_blocks;
        logic [OUT_CNT_W-1:0] live_allocations;
        logic [OUT_CNT_W-1:0] total_releases;
    } t_result;

    typedef struct packed {
        t_cmd             cmd;
        logic [IDX_W-1:0] idx;
    } t_entry;

endpackage

// ===== hdl/fbfl_front.sv =====
`timescale 1ns / 1ps

module fbfl_front (
    input  logic                      i_start,
    input  fbfl_pkg::t_request        i_req,
    input  logic [fbfl_pkg::BC_W-1:0] i_block_count,
    input  logic                      i_full,
    output logic                      o_busy,
    output logic                      o_push,
    output fbfl_pkg::t_entry          o_entry
);
    import fbfl_pkg::*;

    // An item is taken whenever the queue has room.
    assign o_busy = i_full;
    assign o_push = i_start && !i_full;

    always_comb begin
        o_entry.idx = i_req.release_index;
        unique case (i_req.operation)
            OP_ALLOC: begin
                o_entry.cmd = CMD_ALLOC;
            end
            default: begin
                // A release beyond the pool is rejected without touching state.
                if ({1'b0, i_req.release_index} >= i_block_count) begin
                    o_entry.cmd = CMD_REJECT;
                end else begin
                    o_entry.cmd = CMD_RELEASE;
                end
            end
        endcase
    end

endmodule

// ===== hdl/fbfl_queue.sv =====
`timescale 1ns / 1ps

module fbfl_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  fbfl_pkg::t_entry i_entry,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output fbfl_pkg::t_entry o_head
);
    import fbfl_pkg::*;

    t_entry            r_slot [Q_DEPTH];
    logic [Q_AW-1:0]   r_wptr;
    logic [Q_AW-1:0]   r_rptr;
    logic [Q_AW:0]     r_count;

    localparam logic [Q_AW-1:0] LAST = Q_AW'(Q_DEPTH - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_entry;
        end
    end

    assign o_full  = (r_count == (Q_AW + 1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_slot[r_rptr];

endmodule

// ===== hdl/fbfl_back.sv =====
`timescale 1ns / 1ps

module fbfl_back #(
    parameter int unsigned NUM_BLOCKS  = fbfl_pkg::NUM_BLOCKS_DEF,
    parameter int unsigned COUNT_WIDTH = fbfl_pkg::COUNT_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  fbfl_pkg::t_entry          i_entry,
    output logic                      o_pop,
    input  logic                      i_clear,
    input  logic [fbfl_pkg::BC_W-1:0] i_block_count,
    output logic                      o_done,
    output fbfl_pkg::t_result         o_result
);
    import fbfl_pkg::*;

    // Released indices never exceed the index field, so the link store needs
    // no more entries than that field can name.
    localparam int unsigned LINK_DEPTH = (NUM_BLOCKS < 256) ? NUM_BLOCKS : 256;
    localparam int unsigned LINK_AW    = $clog2(LINK_DEPTH);
    localparam int unsigned DEPTH_W    = $clog2(2 * NUM_BLOCKS);
    localparam logic [DEPTH_W-1:0] DEPTH_MAX = DEPTH_W'(2 * NUM_BLOCKS - 1);

    logic [IDX_W-1:0]       r_link_mem [LINK_DEPTH];
    logic [IDX_W-1:0]       r_link;
    logic                   r_stale;
    logic [IDX_W-1:0]       r_top,   n_top;
    logic [DEPTH_W-1:0]     r_depth, n_depth;
    logic [BC_W-1:0]        r_fresh, n_fresh;
    logic [BC_W-1:0]        r_free,  n_free;
    logic [COUNT_WIDTH-1:0] r_alloc, n_alloc;
    logic [COUNT_WIDTH-1:0] r_rel,   n_rel;
    logic                   n_stale;
    logic                   w_link_wr;
    logic                   r_done;
    t_result                r_result, n_result;
    logic [63:0]            w_alloc_wide;
    logic [63:0]            w_rel_wide;

    // A pop from the stack needs the link of the current top, which is one
    // read behind any change of the top.
    assign o_pop = i_valid && !i_clear &&
                   !((i_entry.cmd == CMD_ALLOC) && (r_depth != '0) && r_stale);

    always_comb begin
        n_top     = r_top;
        n_depth   = r_depth;
        n_fresh   = r_fresh;
        n_free    = r_free;
        n_alloc   = r_alloc;
        n_rel     = r_rel;
        n_stale   = 1'b0;
        w_link_wr = 1'b0;
        n_result.status        = ST_OK;
        n_result.granted_index = '0;
        if (o_pop) begin
            unique case (i_entry.cmd)
                CMD_ALLOC: begin
                    if (r_depth != '0) begin
                        n_result.granted_index = r_top;
                        n_top   = r_link;
                        n_depth = r_depth - 1'b1;
                        n_stale = 1'b1;
                    end else if (r_fresh < i_block_count) begin
                        n_result.granted_index = r_fresh[IDX_W-1:0];
                        n_fresh = r_fresh + 1'b1;
                    end else begin
                        n_result.status = ST_EMPTY;
                    end
                    if (n_result.status == ST_OK) begin
                        if (r_free != '0) begin
                            n_free = r_free - 1'b1;
                        end
                        n_alloc = r_alloc + 1'b1;
                    end
                end
                CMD_RELEASE: begin
                    w_link_wr = 1'b1;
                    n_top     = i_entry.idx;
                    n_stale   = 1'b1;
                    if (r_depth != DEPTH_MAX) begin
                        n_depth = r_depth + 1'b1;
                    end
                    if (r_free < i_block_count) begin
                        n_free = r_free + 1'b1;
                    end
                    n_rel = r_rel + 1'b1;
                    if (r_alloc != '0) begin
                        n_alloc = r_alloc - 1'b1;
                    end
                end
                default: begin
                    n_result.status = ST_RANGE;
                end
            endcase
        end
        w_alloc_wide = 64'(n_alloc);
        w_rel_wide   = 64'(n_rel);
        n_result.free_blocks      = n_free;
        n_result.live_allocations = w_alloc_wide[OUT_CNT_W-1:0];
        n_result.total_releases   = w_rel_wide[OUT_CNT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top   <= '0;
            r_depth <= '0;
            r_fresh <= '0;
            r_free  <= i_block_count;
            r_alloc <= '0;
            r_rel   <= '0;
            r_stale <= 1'b1;
            r_done  <= 1'b0;
        end else if (i_clear) begin
            r_top   <= '0;
            r_depth <= '0;
            r_fresh <= '0;
            r_free  <= i_block_count;
            r_alloc <= '0;
            r_rel   <= '0;
            r_stale <= 1'b1;
            r_done  <= 1'b0;
        end else begin
            r_top   <= n_top;
            r_depth <= n_depth;
            r_fresh <= n_fresh;
            r_free  <= n_free;
            r_alloc <= n_alloc;
            r_rel   <= n_rel;
            r_stale <= n_stale;
            r_done  <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_result <= n_result;
        end
    end

    // Link store: the pushed block points at the previous top.
    always_ff @(posedge i_clk) begin
        if (w_link_wr) begin
            r_link_mem[i_entry.idx[LINK_AW-1:0]] <= r_top;
        end
        r_link <= r_link_mem[r_top[LINK_AW-1:0]];
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== hdl/fixed_block_free_list_allocator.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// request   in         start high, busy low      i_req      (fbfl_pkg::t_request)
// result    out        o_done, one cycle         o_result   (fbfl_pkg::t_result)
// config    in         i_cfg_valid, o_cfg_ready  i_cfg_data (block count, 9 bits)
//
// An accepted item enters the queue; the back takes it from there and registers
// its result. Releases, rejected releases and fresh allocations retire one per
// cycle outside configuration writes; a stack allocation right after another
// change of the stack top waits for the registered link read, so back-to-back
// stack allocations each wait for it. Reset and every configuration write return
// the pool to all free at once. The result channel has no backpressure.

module fixed_block_free_list_allocator #(
    parameter int unsigned NUM_BLOCKS  = fbfl_pkg::NUM_BLOCKS_DEF,
    parameter int unsigned COUNT_WIDTH = fbfl_pkg::COUNT_WIDTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  fbfl_pkg::t_request        i_req,
    output logic                      o_done,
    output fbfl_pkg::t_result         o_result,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic [fbfl_pkg::BC_W-1:0] i_cfg_data
);
    import fbfl_pkg::*;

    logic [BC_W-1:0] r_block_count;
    logic [BC_W-1:0] n_block_count;
    logic [BC_W-1:0] w_bc_to_back;
    logic            w_push;
    logic            w_full;
    logic            w_q_valid;
    logic            w_pop;
    t_entry          w_in_entry;
    t_entry          w_head;

    // A block count of zero acts as one block; anything above the pool size
    // acts as the whole pool.
    function automatic logic [BC_W-1:0] f_limit(input logic [BC_W-1:0] v);
        if (v == '0) begin
            return BC_W'(1);
        end else if (32'(v) > NUM_BLOCKS) begin
            return BC_W'(NUM_BLOCKS);
        end else begin
            return v;
        end
    endfunction

    // Always writable (no idle check); software must write it only while idle.
    assign o_cfg_ready   = 1'b1;
    assign n_block_count = f_limit(i_cfg_data);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= f_limit(BC_RESET);
        end else if (i_cfg_valid) begin
            r_block_count <= n_block_count;
        end
    end

    // The back loads its free count from this value on reset and on a write,
    // so it sees the new count in the cycle of the write itself.
    always_comb begin
        if (!i_rst_n) begin
            w_bc_to_back = f_limit(BC_RESET);
        end else if (i_cfg_valid) begin
            w_bc_to_back = n_block_count;
        end else begin
            w_bc_to_back = r_block_count;
        end
    end

    // Front: takes each item and classifies it against the pool size.
    fbfl_front u_front (
        .i_start       (start),
        .i_req         (i_req),
        .i_block_count (r_block_count),
        .i_full        (w_full),
        .o_busy        (busy),
        .o_push        (w_push),
        .o_entry       (w_in_entry)
    );

    // Short queue that lets the front keep accepting while the back waits on
    // a link read.
    fbfl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_in_entry),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_head  (w_head)
    );

    // Back: owns the release stack, the fresh counter and all counters, and
    // registers each result.
    fbfl_back #(
        .NUM_BLOCKS  (NUM_BLOCKS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .i_entry       (w_head),
        .o_pop         (w_pop),
        .i_clear       (i_cfg_valid),
        .i_block_count (w_bc_to_back),
        .o_done        (o_done),
        .o_result      (o_result)
    );

endmodule

// ===== hdl/fbfl_checker.sv =====
`timescale 1ns / 1ps

module fbfl_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic              o_done,
    input fbfl_pkg::t_result o_result
);
    import fbfl_pkg::*;

    // Leaving reset, nothing is pending and the front is ready.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_done && !busy))
        else $error("result or busy right after reset");

    // Only a granted allocation names a block.
    a_grant_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status != ST_OK)) |-> (o_result.granted_index == '0))
        else $error("failed item carries a block index");

    // An empty pool has no free blocks left to count.
    a_empty_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_result.status == ST_EMPTY)) |-> (o_result.free_blocks == '0))
        else $error("pool reported empty with free blocks");

    // A rejected release leaves the release count where the last result had it.
    a_reject_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && $past(o_done) && (o_result.status == ST_RANGE) && !start && !busy)
        |-> (o_result.total_releases == $past(o_result.total_releases)))
        else $error("rejected release changed the release count");

endmodule

bind fixed_block_free_list_allocator fbfl_checker u_fbfl_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);

// ===== bench/tb_fixed_block_free_list_allocator.sv =====
`timescale 1ns / 1ps

module tb_fixed_block_free_list_allocator;

    import fbfl_pkg::*;

    // The pool under test runs with the package defaults.
    localparam int unsigned POOL_BLOCKS = NUM_BLOCKS_DEF;
    localparam int unsigned DEPTH_MAX   = 2 * POOL_BLOCKS - 1;

    // The limit leaves plenty of headroom over the slowest correct run, for long
    // gaps and the drains around register writes.
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic            i_clk       = 1'b0;
    logic            i_rst_n     = 1'b0;
    logic            start       = 1'b0;
    logic            busy;
    t_request        req_drv     = '0;
    logic            o_done;
    t_result         o_result;
    logic            i_cfg_valid = 1'b0;
    logic            o_cfg_ready;
    logic [BC_W-1:0] i_cfg_data  = '0;

    fixed_block_free_list_allocator #(
        .NUM_BLOCKS  (NUM_BLOCKS_DEF),
        .COUNT_WIDTH (COUNT_WIDTH_DEF)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (req_drv),
        .o_done      (o_done),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predicted pool state. It mirrors the allocator: a stack of released
    // blocks chained through link_mem, in front of a counter of blocks that
    // have never been handed out.
    // ------------------------------------------------------------------
    logic [IDX_W-1:0]     link_mem [POOL_BLOCKS];
    logic [IDX_W-1:0]     stk_top;
    int unsigned          stk_depth;
    logic [BC_W-1:0]      fresh_next;
    logic [BC_W-1:0]      free_cnt;
    logic [OUT_CNT_W-1:0] live_cnt;
    logic [OUT_CNT_W-1:0] rel_cnt;
    logic [BC_W-1:0]      pool_size;

    t_request pending_requests [$];
    t_result  expected_results [$];
    int unsigned items_queued   = 0;
    int unsigned items_accepted = 0;
    int unsigned mismatch_count = 0;
    int unsigned cycle_count    = 0;

    // A block count of zero behaves as one, anything above the pool as the pool.
    function automatic logic [BC_W-1:0] clamp_count(logic [BC_W-1:0] v);
        if (v == 0) return BC_W'(1);
        if (v > POOL_BLOCKS) return BC_W'(POOL_BLOCKS);
        return v;
    endfunction

    // Reset and every register write leave the pool entirely free.
    function automatic void empty_pool(logic [BC_W-1:0] count);
        pool_size  = clamp_count(count);
        stk_top    = '0;
        stk_depth  = 0;
        fresh_next = '0;
        free_cnt   = pool_size;
        live_cnt   = '0;
        rel_cnt    = '0;
    endfunction

    // Works out the result of one item and advances the predicted pool.
    function automatic t_result apply_pool_request(t_request r);
        t_result res;
        res        = '0;
        res.status = ST_OK;
        if (r.operation == OP_ALLOC) begin
            if (stk_depth != 0) begin
                res.granted_index = stk_top;
                stk_top           = link_mem[stk_top];
                stk_depth--;
            end else if (fresh_next < pool_size) begin
                res.granted_index = fresh_next[IDX_W-1:0];
                fresh_next++;
            end else begin
                res.status = ST_EMPTY;
            end
            if (res.status == ST_OK) begin
                if (free_cnt != 0) free_cnt--;
                live_cnt++;
            end
        end else if (r.release_index >= pool_size) begin
            // An index outside the pool is flagged and changes nothing.
            res.status = ST_RANGE;
        end else begin
            // Double releases are pushed like any other; the depth saturates
            // but the push itself always happens.
            link_mem[r.release_index] = stk_top;
            stk_top = r.release_index;
            if (stk_depth < DEPTH_MAX) stk_depth++;
            if (free_cnt < pool_size) free_cnt++;
            rel_cnt++;
            if (live_cnt != 0) live_cnt--;
        end
        res.free_blocks      = free_cnt;
        res.live_allocations = live_cnt;
        res.total_releases   = rel_cnt;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver. Gaps between items are mostly short with an occasional long
    // one, and some stretches run with no gaps at all.
    // ------------------------------------------------------------------
    int unsigned gap_left  = 0;
    bit          no_gaps   = 1'b0;

    function automatic int unsigned pick_gap();
        int unsigned r;
        if ($urandom_range(0, 15) == 0) no_gaps = ~no_gaps;
        if (no_gaps) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            // An item is taken at an edge where start is high and busy low.
            if (start && !busy) begin
                expected_results.push_back(apply_pool_request(req_drv));
                items_accepted++;
                gap_left = pick_gap();
            end
            // While the block is busy the current item is held as it is.
            if (!(start && busy)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_requests.size() != 0) begin
                    start   <= 1'b1;
                    req_drv <= pending_requests.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor. The result port has no back-pressure, so every strobe is
    // taken and checked field by field against the oldest prediction.
    // ------------------------------------------------------------------
    task automatic check_field(string fname, logic [OUT_CNT_W-1:0] want,
                               logic [OUT_CNT_W-1:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d actual %0d", $time, fname, want, got);
            mismatch_count++;
        end
    endtask

    t_result want_res;

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result expected none actual %p",
                         $time, o_result);
                mismatch_count++;
            end else begin
                want_res = expected_results.pop_front();
                check_field("status", OUT_CNT_W'(want_res.status),
                            OUT_CNT_W'(o_result.status));
                check_field("granted_index", OUT_CNT_W'(want_res.granted_index),
                            OUT_CNT_W'(o_result.granted_index));
                check_field("free_blocks", OUT_CNT_W'(want_res.free_blocks),
                            OUT_CNT_W'(o_result.free_blocks));
                check_field("live_allocations", want_res.live_allocations,
                            o_result.live_allocations);
                check_field("total_releases", want_res.total_releases,
                            o_result.total_releases);
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("fixed_block_free_list_allocator: mismatch");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic queue_item(logic op, logic [IDX_W-1:0] idx);
        t_request r;
        r.operation     = op;
        r.release_index = idx;
        pending_requests.push_back(r);
        items_queued++;
    endtask

    // Waits until every item has been taken and every result has come back,
    // then lets the pipeline settle.
    task automatic wait_for_drain();
        do @(negedge i_clk);
        while (items_accepted != items_queued || expected_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // The register is only written while the block is idle.
    task automatic write_block_count(logic [BC_W-1:0] v);
        wait_for_drain();
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        empty_pool(v);
        @(negedge i_clk);
    endtask

    // A random phase is built from bursts: runs of allocations that drain the
    // pool, runs of releases that fill the stack, and mixed runs. Releases are
    // mostly in range; the rest use any index so that out-of-range requests and
    // every index bit are covered.
    task automatic queue_random_phase(int unsigned n_items);
        int unsigned done_items;
        int unsigned burst;
        int unsigned mode;
        int unsigned i;
        logic        op;
        logic [IDX_W-1:0] idx;
        done_items = 0;
        while (done_items < n_items) begin
            mode  = $urandom_range(0, 2);
            burst = $urandom_range(1, (pool_size > 16) ? 40 : 2 * pool_size + 4);
            for (i = 0; i < burst && done_items < n_items; i++) begin
                case (mode)
                    0:       op = ($urandom_range(0, 99) < 85) ? OP_ALLOC : OP_RELEASE;
                    1:       op = ($urandom_range(0, 99) < 85) ? OP_RELEASE : OP_ALLOC;
                    default: op = 1'($urandom_range(0, 1));
                endcase
                if ($urandom_range(0, 99) < 85)
                    idx = IDX_W'($urandom_range(0, pool_size - 1));
                else
                    idx = IDX_W'($urandom_range(0, 255));
                queue_item(op, idx);
                done_items++;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    logic [BC_W-1:0] phase_cfg;
    int unsigned     p;
    int unsigned     k;

    initial begin
        empty_pool(BC_RESET);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset pool of 256: fresh grants, releases at both ends of the index
        // range, a double release that makes one block come out twice, then a
        // fresh block once the stack is used up.
        queue_item(OP_ALLOC, 8'hFF);
        queue_item(OP_ALLOC, 8'h00);
        queue_item(OP_RELEASE, 8'd255);
        queue_item(OP_RELEASE, 8'd0);
        queue_item(OP_ALLOC, 8'h00);
        queue_item(OP_ALLOC, 8'h00);
        queue_item(OP_RELEASE, 8'd1);
        queue_item(OP_RELEASE, 8'd1);
        queue_item(OP_ALLOC, 8'h00);
        queue_item(OP_ALLOC, 8'h00);
        queue_item(OP_ALLOC, 8'h00);

        // Smallest pool: empty pool on allocate, out-of-range releases, free
        // count held at the pool size and live count held at zero.
        write_block_count(9'd1);
        queue_item(OP_ALLOC, 8'h00);
        queue_item(OP_ALLOC, 8'h00);
        queue_item(OP_RELEASE, 8'd1);
        queue_item(OP_RELEASE, 8'd255);
        queue_item(OP_RELEASE, 8'd0);
        queue_item(OP_RELEASE, 8'd0);
        queue_item(OP_RELEASE, 8'd0);
        queue_item(OP_ALLOC, 8'h00);
        queue_item(OP_ALLOC, 8'h00);

        // A count of zero behaves as one, and an oversize count as the pool.
        write_block_count(9'd0);
        queue_item(OP_ALLOC, 8'h00);
        queue_item(OP_ALLOC, 8'h00);
        write_block_count(9'h1FF);
        queue_item(OP_RELEASE, 8'd255);
        queue_item(OP_ALLOC, 8'h00);

        // Many double releases into a two-block pool grow the stack well past
        // the pool size while the free count stays at the pool size; then pop
        // a few of them.
        write_block_count(9'd2);
        for (k = 0; k < 20; k++) queue_item(OP_RELEASE, IDX_W'($urandom_range(0, 1)));
        for (k = 0; k < 6; k++) queue_item(OP_ALLOC, 8'h00);

        // Random phases over a spread of pool sizes, extremes among them.
        for (p = 0; p < 10; p++) begin
            case (p)
                0:       phase_cfg = 9'd3;
                1:       phase_cfg = 9'd256;
                2:       phase_cfg = 9'd1;
                3:       phase_cfg = 9'd16;
                4:       phase_cfg = BC_W'($urandom_range(1, 8));
                5:       phase_cfg = 9'h1FF;
                6:       phase_cfg = BC_W'($urandom_range(0, 511));
                7:       phase_cfg = 9'd2;
                8:       phase_cfg = 9'd0;
                default: phase_cfg = BC_W'($urandom_range(4, 12));
            endcase
            write_block_count(phase_cfg);
            queue_random_phase(55);
        end

        wait_for_drain();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("fixed_block_free_list_allocator: match");
        end else begin
            $display("fixed_block_free_list_allocator: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/fbfl_pkg.sv
hdl/fbfl_front.sv
hdl/fbfl_queue.sv
hdl/fbfl_back.sv
hdl/fixed_block_free_list_allocator.sv
hdl/fbfl_checker.sv
bench/tb_fixed_block_free_list_allocator.sv
